// File: sv/hrl_pkg.sv
// Shared types for the hex record loader parser: result kinds, error codes, result struct.
package hrl_pkg;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_ACCEPT = 2'd1,
		KIND_END    = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	// Error codes
	typedef enum logic [2:0] {
		ERR_NONE        = 3'd0,
		ERR_NO_COLON    = 3'd1,
		ERR_HDR_DIGIT   = 3'd2,
		ERR_DATA_DIGIT  = 3'd3,
		ERR_CKSUM_DIGIT = 3'd4,
		ERR_TYPE        = 3'd5,
		ERR_CKSUM       = 3'd6
	} err_t;

	// One result transaction
	typedef struct packed {
		kind_t       kind;
		logic [15:0] load_address;
		logic [7:0]  data_byte;
		err_t        error_code;
	} result_t;

endpackage

// File: sv/hex_record_loader_parser.sv
// Top level of the hex record loader parser: input register, parse step, result register.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------------
//  source  | src_valid | src_stall | char_in
//  result  | res_valid | res_stall | kind, load_address, data_byte, error_code
//
// One character is taken per cycle unless src_stall is high; it is held in the input register.
// The parse step then updates the record state and loads any result into the result register.
// A character that causes no result still waits while a stalled result is held.
// Reset puts the parser at line start, clears the record state and empties both registers.
// After an error or an end record every character is taken and dropped until reset.
module hex_record_loader_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic [7:0]  char_in,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [1:0]  kind,
	output logic [15:0] load_address,
	output logic [7:0]  data_byte,
	output logic [2:0]  error_code
);

	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             ready;
	logic             advance;
	logic             produce;
	hrl_pkg::result_t step_result;
	hrl_pkg::result_t result_q;

	// A character moves through the step when the result register can take its result
	assign advance = valid_s1 && ready;

	hrl_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.char_in   (char_in),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.char_s1   (char_s1)
	);

	hrl_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (advance),
		.char_s1 (char_s1),
		.produce (produce),
		.result  (step_result)
	);

	hrl_res_reg u_res (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && produce),
		.result_d  (step_result),
		.ready     (ready),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.result_q  (result_q)
	);

	// Result fields
	assign kind         = result_q.kind;
	assign load_address = result_q.load_address;
	assign data_byte    = result_q.data_byte;
	assign error_code   = result_q.error_code;

`ifndef ASSERT_OFF
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> valid_s1 && res_valid && res_stall)
		else $error("source stalled without a blocked result");
	a_data_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind != hrl_pkg::KIND_DATA |-> data_byte == 8'd0)
		else $error("data byte set on a non-data result");
	a_result_needs_char: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(valid_s1))
		else $error("result without a character");
`endif

endmodule

// File: sv/hrl_in_stage.sv
// Input register of the parser: holds one character until the parse step can take it.
module hrl_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       src_valid,
	output logic       src_stall,
	input  logic [7:0] char_in,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] char_s1
);

	logic accept;

	// Stall only while a held character cannot move on
	assign src_stall = valid_s1 && !advance;
	assign accept    = src_valid && !src_stall;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Character payload
	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_in;
		end
	end

`ifndef ASSERT_OFF
	a_advance_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> valid_s1)
		else $error("advance without a held character");
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted character not held");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |=> valid_s1 && $stable(char_s1))
		else $error("held character lost during stall");
`endif

endmodule

// File: sv/hrl_step.sv
// Per-character parse step: record state registers and the combinational next-state logic.
module hrl_step (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [7:0]       char_s1,
	output logic             produce,
	output hrl_pkg::result_t result
);

	localparam logic [7:0] ASCII_COLON = 8'h3a;
	localparam logic [7:0] ASCII_LF    = 8'h0a;

	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_HEADER = 3'd1,
		PH_DATA   = 3'd2,
		PH_CKSUM  = 3'd3,
		PH_SKIP   = 3'd4
	} phase_t;

	phase_t      phase_q,  phase_d;
	logic [2:0]  digit_q,  digit_d;
	logic [3:0]  high_q,   high_d;
	logic [7:0]  left_q,   left_d;
	logic [7:0]  offset_q, offset_d;
	logic [15:0] addr_q,   addr_d;
	logic [7:0]  type_q,   type_d;
	logic [7:0]  sum_q,    sum_d;
	logic        halted_q, halted_d;

	// Hex digit decode, either case; bit 4 flags a valid digit
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	// Next state and result for the character in the input register
	always_comb begin
		logic [4:0] hx;
		logic [7:0] b;
		logic [7:0] left_m1;
		phase_d  = phase_q;
		digit_d  = digit_q;
		high_d   = high_q;
		left_d   = left_q;
		offset_d = offset_q;
		addr_d   = addr_q;
		type_d   = type_q;
		sum_d    = sum_q;
		halted_d = halted_q;
		produce  = 1'b0;
		result   = '0;
		hx       = hex_decode(char_s1);
		b        = {high_q, hx[3:0]};
		left_m1  = left_q - 8'd1;
		if (!halted_q) begin
			unique case (phase_q)
				PH_SKIP: begin
					if (char_s1 == ASCII_LF) begin
						phase_d = PH_START;
					end
				end
				PH_HEADER, PH_DATA, PH_CKSUM: begin
					if (!hx[4]) begin
						// non-hex character inside a field
						halted_d          = 1'b1;
						produce           = 1'b1;
						result.kind       = hrl_pkg::KIND_ERROR;
						if (phase_q == PH_HEADER) begin
							result.error_code = hrl_pkg::ERR_HDR_DIGIT;
						end else if (phase_q == PH_DATA) begin
							result.error_code   = hrl_pkg::ERR_DATA_DIGIT;
							result.load_address = addr_q;
						end else begin
							result.error_code   = hrl_pkg::ERR_CKSUM_DIGIT;
							result.load_address = addr_q;
						end
					end else if (!digit_q[0]) begin
						// first digit of a byte
						high_d  = hx[3:0];
						digit_d = digit_q + 3'd1;
					end else if (phase_q == PH_HEADER) begin
						sum_d = sum_q + b;
						unique case (digit_q[2:1])
							2'd0: left_d = b;
							2'd1: addr_d = {b, 8'h00};
							2'd2: addr_d = addr_q | {8'h00, b};
							default: type_d = b;
						endcase
						if (digit_q[2:1] != 2'd3) begin
							digit_d = digit_q + 3'd1;
						end else begin
							digit_d = 3'd0;
							if (b == 8'd1) begin
								// end record halts the load
								halted_d            = 1'b1;
								produce             = 1'b1;
								result.kind         = hrl_pkg::KIND_END;
								result.load_address = addr_q;
							end else if (b != 8'd0) begin
								halted_d            = 1'b1;
								produce             = 1'b1;
								result.kind         = hrl_pkg::KIND_ERROR;
								result.error_code   = hrl_pkg::ERR_TYPE;
								result.load_address = addr_q;
							end else begin
								phase_d = (left_q == 8'd0) ? PH_CKSUM : PH_DATA;
							end
						end
					end else if (phase_q == PH_DATA) begin
						// tentative data byte
						digit_d             = 3'd0;
						sum_d               = sum_q + b;
						offset_d            = offset_q + 8'd1;
						left_d              = left_m1;
						produce             = 1'b1;
						result.kind         = hrl_pkg::KIND_DATA;
						result.load_address = addr_q + {8'h00, offset_q};
						result.data_byte    = b;
						if (left_m1 == 8'd0) begin
							phase_d = PH_CKSUM;
						end
					end else begin
						// checksum byte closes the record
						digit_d             = 3'd0;
						produce             = 1'b1;
						result.load_address = addr_q;
						if (sum_q + b != 8'd0) begin
							halted_d          = 1'b1;
							result.kind       = hrl_pkg::KIND_ERROR;
							result.error_code = hrl_pkg::ERR_CKSUM;
						end else begin
							phase_d     = PH_SKIP;
							result.kind = hrl_pkg::KIND_ACCEPT;
						end
					end
				end
				default: begin
					// line start, also unused phase codes
					if (char_s1 != ASCII_COLON) begin
						halted_d          = 1'b1;
						produce           = 1'b1;
						result.kind       = hrl_pkg::KIND_ERROR;
						result.error_code = hrl_pkg::ERR_NO_COLON;
					end else begin
						phase_d  = PH_HEADER;
						digit_d  = 3'd0;
						high_d   = 4'd0;
						left_d   = 8'd0;
						offset_d = 8'd0;
						addr_d   = 16'd0;
						type_d   = 8'd0;
						sum_d    = 8'd0;
					end
				end
			endcase
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			digit_q  <= 3'd0;
			high_q   <= 4'd0;
			left_q   <= 8'd0;
			offset_q <= 8'd0;
			addr_q   <= 16'd0;
			type_q   <= 8'd0;
			sum_q    <= 8'd0;
			halted_q <= 1'b0;
		end else if (fire) begin
			phase_q  <= phase_d;
			digit_q  <= digit_d;
			high_q   <= high_d;
			left_q   <= left_d;
			offset_q <= offset_d;
			addr_q   <= addr_d;
			type_q   <= type_d;
			sum_q    <= sum_d;
			halted_q <= halted_d;
		end
	end

`ifndef ASSERT_OFF
	a_halted_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halted flag cleared without reset");
	a_halted_silent: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !produce)
		else $error("result produced while halted");
	a_data_in_data_phase: assert property (@(posedge clk) disable iff (!arst_n)
		produce && result.kind == hrl_pkg::KIND_DATA |-> phase_q == PH_DATA && left_q != 8'd0)
		else $error("data byte outside data phase");
	a_record_closes: assert property (@(posedge clk) disable iff (!arst_n)
		fire && produce && result.kind == hrl_pkg::KIND_ACCEPT |=> phase_q == PH_SKIP)
		else $error("accepted record did not move to line skip");
`endif

endmodule

// File: sv/hrl_res_reg.sv
// Result register of the parser: holds one result transaction until the sink takes it.
module hrl_res_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  hrl_pkg::result_t result_d,
	output logic             ready,
	output logic             res_valid,
	input  logic             res_stall,
	output hrl_pkg::result_t result_q
);

	// Free when empty or when the held result leaves this cycle
	assign ready = !res_valid || !res_stall;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (load) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_d;
		end
	end

`ifndef ASSERT_OFF
	a_load_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> ready)
		else $error("result overwritten while stalled");
	a_error_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && result_q.kind == hrl_pkg::KIND_ERROR |-> result_q.error_code != hrl_pkg::ERR_NONE)
		else $error("error result without an error code");
	a_data_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && result_q.kind != hrl_pkg::KIND_ERROR |-> result_q.error_code == hrl_pkg::ERR_NONE)
		else $error("non-error result with an error code");
`endif

endmodule

// File: dv/tb.sv
// Testbench for the hex record loader parser: record stimulus, per-character prediction, result checks.
module tb;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam int RUN_CHARS = 1400;
	localparam int QUIET_FROM = 1150;

	// Parser phases as the predictor tracks them
	typedef enum logic [2:0] {
		PH_START,
		PH_HEADER,
		PH_DATA,
		PH_CKSUM,
		PH_SKIP
	} phase_t;

	// How the load is brought to its end
	typedef enum int {
		END_BLANK,
		END_CR,
		END_JUNK,
		END_HDR_DIGIT,
		END_DATA_DIGIT,
		END_CKSUM_DIGIT,
		END_TYPE,
		END_CKSUM,
		END_RECORD
	} ending_t;

	// Character-level predictor and in-order result checker
	class loader_scoreboard;
		phase_t      phase = PH_START;
		logic [2:0]  digit_count = '0;
		logic [3:0]  high_nibble = '0;
		logic [7:0]  bytes_left = '0;
		logic [7:0]  byte_offset = '0;
		logic [15:0] record_address = '0;
		logic [7:0]  record_type = '0;
		logic [7:0]  running_sum = '0;
		bit          halted = 1'b0;
		hrl_pkg::result_t pending_results[$];
		int          fail_count = 0;

		function void push_result(hrl_pkg::kind_t k, logic [15:0] a, logic [7:0] d,
			hrl_pkg::err_t e);
			hrl_pkg::result_t r;
			r.kind = k;
			r.load_address = a;
			r.data_byte = d;
			r.error_code = e;
			pending_results.push_back(r);
		endfunction

		function void halt_on(hrl_pkg::err_t e, logic [15:0] a);
			halted = 1'b1;
			push_result(hrl_pkg::KIND_ERROR, a, 8'h00, e);
		endfunction

		// Note one accepted character and queue the result it causes, if any
		function void take_char(logic [7:0] c);
			logic [3:0]  nib;
			logic [7:0]  b;
			logic [15:0] addr;
			bit          is_hex;
			if (halted)
				return;
			// trailing text after an accepted record
			if (phase == PH_SKIP) begin
				if (c == CH_LF)
					phase = PH_START;
				return;
			end
			// line start: only a colon opens a record
			if (phase != PH_HEADER && phase != PH_DATA && phase != PH_CKSUM) begin
				if (c != CH_COLON) begin
					halt_on(hrl_pkg::ERR_NO_COLON, 16'h0000);
					return;
				end
				phase = PH_HEADER;
				digit_count = '0;
				high_nibble = '0;
				bytes_left = '0;
				byte_offset = '0;
				record_address = '0;
				record_type = '0;
				running_sum = '0;
				return;
			end
			// hex digit of either case
			is_hex = 1'b1;
			nib = '0;
			if (c >= "0" && c <= "9")
				nib = 4'(c - "0");
			else if (c >= "a" && c <= "f")
				nib = 4'(c - "a" + 8'd10);
			else if (c >= "A" && c <= "F")
				nib = 4'(c - "A" + 8'd10);
			else
				is_hex = 1'b0;
			if (!is_hex) begin
				case (phase)
					PH_HEADER: halt_on(hrl_pkg::ERR_HDR_DIGIT, 16'h0000);
					PH_DATA: halt_on(hrl_pkg::ERR_DATA_DIGIT, record_address);
					default: halt_on(hrl_pkg::ERR_CKSUM_DIGIT, record_address);
				endcase
				return;
			end
			// first digit of a byte
			if (!digit_count[0]) begin
				high_nibble = nib;
				digit_count = digit_count + 3'd1;
				return;
			end
			b = {high_nibble, nib};
			// header bytes: count, address high, address low, type
			if (phase == PH_HEADER) begin
				running_sum = running_sum + b;
				case (digit_count[2:1])
					2'd0: bytes_left = b;
					2'd1: record_address = {b, 8'h00};
					2'd2: record_address = record_address | {8'h00, b};
					default: record_type = b;
				endcase
				if (digit_count[2:1] != 2'd3) begin
					digit_count = digit_count + 3'd1;
					return;
				end
				digit_count = '0;
				if (record_type == 8'd1) begin
					halted = 1'b1;
					push_result(hrl_pkg::KIND_END, record_address, 8'h00, hrl_pkg::ERR_NONE);
				end else if (record_type != 8'd0) begin
					halt_on(hrl_pkg::ERR_TYPE, record_address);
				end else begin
					phase = (bytes_left == 8'd0) ? PH_CKSUM : PH_DATA;
				end
				return;
			end
			digit_count = '0;
			// data byte, emitted tentatively at a wrapping address
			if (phase == PH_DATA) begin
				addr = record_address + {8'h00, byte_offset};
				running_sum = running_sum + b;
				byte_offset = byte_offset + 8'd1;
				bytes_left = bytes_left - 8'd1;
				if (bytes_left == 8'd0)
					phase = PH_CKSUM;
				push_result(hrl_pkg::KIND_DATA, addr, b, hrl_pkg::ERR_NONE);
				return;
			end
			// checksum byte closes the record
			b = b + running_sum;
			if (b != 8'd0) begin
				halt_on(hrl_pkg::ERR_CKSUM, record_address);
			end else begin
				phase = PH_SKIP;
				push_result(hrl_pkg::KIND_ACCEPT, record_address, 8'h00, hrl_pkg::ERR_NONE);
			end
		endfunction

		task report_mismatch(string msg);
			$display("%0t mismatch: %s", $time, msg);
			fail_count++;
		endtask

		// Compare one accepted result with the oldest prediction
		task check_result(hrl_pkg::result_t got);
			hrl_pkg::result_t want;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d addr %h data %h err %0d",
					got.kind, got.load_address, got.data_byte, got.error_code));
				return;
			end
			want = pending_results.pop_front();
			if (got.kind !== want.kind)
				report_mismatch($sformatf("kind %0d, predicted %0d", got.kind, want.kind));
			if (got.load_address !== want.load_address)
				report_mismatch($sformatf("load_address %h, predicted %h",
					got.load_address, want.load_address));
			if (got.data_byte !== want.data_byte)
				report_mismatch($sformatf("data_byte %h, predicted %h",
					got.data_byte, want.data_byte));
			if (got.error_code !== want.error_code)
				report_mismatch($sformatf("error_code %0d, predicted %0d",
					got.error_code, want.error_code));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        src_valid;
	logic        src_stall;
	logic [7:0]  char_in;
	logic        res_valid;
	logic        res_stall;
	logic [1:0]  kind;
	logic [15:0] load_address;
	logic [7:0]  data_byte;
	logic [2:0]  error_code;

	loader_scoreboard sb;
	logic [7:0] line_buf[$];
	int  chars_taken = 0;
	bit  src_idle_on = 1'b1;
	bit  res_idle_on = 1'b1;

	hex_record_loader_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.char_in(char_in),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.kind(kind),
		.load_address(load_address),
		.data_byte(data_byte),
		.error_code(error_code)
	);

	// 20-unit clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Result side: random stall bursts
	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (res_idle_on && $urandom_range(0, 7) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	// Check every accepted result transaction
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(hrl_pkg::result_t'({kind, load_address, data_byte, error_code}));
	end

	// Send one character; returns at the falling edge after it is accepted
	task automatic send_char(input logic [7:0] c);
		if (src_idle_on && $urandom_range(0, 7) == 0) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		src_valid <= 1'b1;
		char_in <= c;
		do @(posedge clk); while (src_stall);
		if (!sb.halted)
			chars_taken++;
		sb.take_char(c);
		@(negedge clk);
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 4'd10)
			return "0" + n;
		return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 8'd10);
	endfunction

	function automatic void put_byte(logic [7:0] b);
		line_buf.push_back(hex_char(b[7:4]));
		line_buf.push_back(hex_char(b[3:0]));
	endfunction

	function automatic logic [7:0] non_hex_char();
		logic [7:0] c;
		do
			c = 8'($urandom);
		while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
		return c;
	endfunction

	// Build one line: colon, header, random data, checksum plus skew, trailing text, optional CR, newline
	function automatic void compose_record(int unsigned count, logic [15:0] addr,
		logic [7:0] rtype, logic [7:0] skew, int unsigned junk, bit cr);
		logic [7:0] sum;
		logic [7:0] b;
		line_buf.delete();
		line_buf.push_back(CH_COLON);
		sum = count[7:0] + addr[15:8] + addr[7:0] + rtype;
		put_byte(count[7:0]);
		put_byte(addr[15:8]);
		put_byte(addr[7:0]);
		put_byte(rtype);
		for (int i = 0; i < count; i++) begin
			b = 8'($urandom);
			sum = sum + b;
			put_byte(b);
		end
		put_byte(8'h00 - sum + skew);
		// any byte but newline may trail the checksum
		repeat (junk) begin
			b = 8'($urandom);
			line_buf.push_back(b == CH_LF ? ~b : b);
		end
		if (cr)
			line_buf.push_back(CH_CR);
		line_buf.push_back(CH_LF);
	endfunction

	task automatic send_line();
		foreach (line_buf[i])
			send_char(line_buf[i]);
	endtask

	// Well-formed data record with random size, address and trailing text
	task automatic send_random_record();
		int unsigned count;
		int unsigned pick;
		logic [15:0] addr;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			count = $urandom_range(0, 8);
		else if (pick < 96)
			count = $urandom_range(9, 40);
		else
			count = $urandom_range(128, 255);
		pick = $urandom_range(0, 9);
		if (pick == 0)
			addr = 16'h0000;
		else if (pick == 1)
			addr = 16'(16'hFFFF - $urandom_range(0, 8));
		else
			addr = 16'($urandom);
		compose_record(count, addr, 8'h00, 8'h00,
			$urandom_range(0, 1) ? 0 : $urandom_range(0, 4), 1'($urandom_range(0, 1)));
		send_line();
	endtask

	// One terminating case, then characters the halted parser must drop
	task automatic send_closing_case();
		ending_t     how;
		int unsigned count;
		logic [15:0] addr;
		logic [7:0]  c;
		how = ending_t'($urandom_range(END_BLANK, END_RECORD));
		count = $urandom_range(0, 6);
		addr = 16'($urandom);
		case (how)
			END_BLANK: send_char(CH_LF);
			END_CR: send_char(CH_CR);
			END_JUNK: begin
				do
					c = 8'($urandom);
				while (c == CH_COLON);
				send_char(c);
			end
			END_HDR_DIGIT: begin
				compose_record(count, addr, 8'h00, 8'h00, 0, 1'b0);
				line_buf[$urandom_range(1, 8)] = non_hex_char();
				send_line();
			end
			END_DATA_DIGIT: begin
				count = $urandom_range(1, 6);
				compose_record(count, addr, 8'h00, 8'h00, 0, 1'b0);
				line_buf[9 + $urandom_range(0, 2 * count - 1)] = non_hex_char();
				send_line();
			end
			END_CKSUM_DIGIT: begin
				compose_record(count, addr, 8'h00, 8'h00, 0, 1'b0);
				line_buf[9 + 2 * count + $urandom_range(0, 1)] = non_hex_char();
				send_line();
			end
			END_TYPE: begin
				compose_record(count, addr, 8'($urandom_range(2, 255)), 8'h00, 0, 1'b0);
				send_line();
			end
			END_CKSUM: begin
				compose_record(count, addr, 8'h00, 8'($urandom_range(1, 255)), 0, 1'b0);
				send_line();
			end
			default: begin
				// end record; its checksum is never read
				compose_record(count, addr, 8'h01,
					$urandom_range(0, 1) ? 8'h00 : 8'($urandom), 0, 1'b0);
				send_line();
			end
		endcase
		repeat (12) send_char(8'($urandom));
	endtask

	// Reset, directed records, random records, closing case, drain
	initial begin
		int unsigned mode;
		int unsigned drain_cycles;
		hrl_pkg::result_t left;
		sb = new;
		arst_n = 1'b0;
		src_valid = 1'b0;
		char_in = 8'h00;
		drain_cycles = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero byte count at the top address
		compose_record(0, 16'hFFFF, 8'h00, 8'h00, 0, 1'b0);
		send_line();
		// data addresses wrap past the top
		compose_record(3, 16'hFFFE, 8'h00, 8'h00, 0, 1'b1);
		send_line();
		// trailing text of random bytes, then CR LF
		compose_record(1, 16'h0000, 8'h00, 8'h00, 4, 1'b1);
		send_line();

		while (chars_taken < RUN_CHARS) begin
			if (chars_taken >= QUIET_FROM) begin
				src_idle_on = 1'b0;
				res_idle_on = 1'b0;
			end else begin
				mode = $urandom_range(0, 3);
				src_idle_on = mode[0];
				res_idle_on = mode[1];
			end
			send_random_record();
		end
		src_idle_on = 1'b0;
		res_idle_on = 1'b0;
		send_closing_case();
		src_valid <= 1'b0;

		// drain, then give the two-stage pipe time to show anything extra
		while (sb.pending_results.size() != 0 && drain_cycles < 5000) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (10) @(posedge clk);
		while (sb.pending_results.size() != 0) begin
			left = sb.pending_results.pop_front();
			sb.report_mismatch($sformatf("missing result kind %0d addr %h data %h err %0d",
				left.kind, left.load_address, left.data_byte, left.error_code));
		end
		if (sb.fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
